// ===== hw/rtl/mmf_pkg.sv =====
// Shared types and constants for the multiset mode finder.
`timescale 1ns / 1ps

package mmf_pkg;

    localparam int VALUE_W     = 32;
    localparam int OCC_W       = 7;
    localparam int MAX_RESULTS = 64;
    localparam int OCC_MAX     = 127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_START,
        ST_CNT_SCAN,
        ST_CNT_COMMIT,
        ST_EMIT_START,
        ST_EMIT_SCAN,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic cnt_start;
        logic cnt_mode;
        logic cnt_commit;
        logic emit_start;
        logic emit_mode;
        logic emit_commit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic i_last;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/mmf_ctrl.sv =====
// Sequencer for loading, counting and result emission.
`timescale 1ns / 1ps

module mmf_ctrl
    import mmf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    is_last,
    output logic    item_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && is_last)
                begin
                    state_next = ST_CNT_START;
                end
            end
            ST_CNT_START:
            begin
                state_next = ST_CNT_SCAN;
            end
            ST_CNT_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_CNT_COMMIT;
                end
            end
            ST_CNT_COMMIT:
            begin
                state_next = status.i_last ? ST_EMIT_START : ST_CNT_START;
            end
            ST_EMIT_START:
            begin
                state_next = ST_EMIT_SCAN;
            end
            ST_EMIT_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = status.emit_last ? ST_IDLE : ST_EMIT_START;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid;
            end
            ST_CNT_START:
            begin
                cmd.cnt_start = 1'b1;
            end
            ST_CNT_SCAN:
            begin
                cmd.cnt_mode = 1'b1;
            end
            ST_CNT_COMMIT:
            begin
                cmd.cnt_commit = 1'b1;
            end
            ST_EMIT_START:
            begin
                cmd.emit_start = 1'b1;
            end
            ST_EMIT_SCAN:
            begin
                cmd.emit_mode = 1'b1;
            end
            ST_EMIT_OUT:
            begin
                cmd.emit_commit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mmf_datapath.sv =====
// Item store, occurrence counting, tie ordering and output register.
`timescale 1ns / 1ps

module mmf_datapath
    import mmf_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [VALUE_W-1:0] value,
    input  logic               is_last,
    output logic               mode_valid,
    input  logic               mode_stall,
    output logic [VALUE_W-1:0] mode_value,
    output logic [OCC_W-1:0]   occurrences,
    output logic               overflow,
    output logic               last_mode
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int FW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (FW > OCC_W) ? FW : OCC_W;

    logic [VALUE_W-1:0] store_mem [CAPACITY];
    logic [FW-1:0]      cnt_mem   [CAPACITY];

    logic [FW-1:0]      fill_reg;
    logic               ovf_reg;
    logic [IW-1:0]      i_reg;
    logic [FW-1:0]      j_reg;
    logic               scan_on_reg;
    logic               rv_reg;
    logic [VALUE_W-1:0] rdata_reg;
    logic [FW-1:0]      rcnt_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [FW-1:0]      occ_reg;
    logic [FW-1:0]      best_reg;
    logic [VALUE_W-1:0] prev_reg;
    logic               have_prev_reg;
    logic [VALUE_W-1:0] min1_reg;
    logic               have1_reg;
    logic [VALUE_W-1:0] min2_reg;
    logic               have2_reg;
    logic [OCC_W-1:0]   emitted_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [OCC_W-1:0]   out_occ_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    logic               full;
    logic               issue;
    logic               cand;
    logic [CMPW-1:0]    best_ext;
    logic [OCC_W-1:0]   occ_sat;
    logic [FW-1:0]      best_next;

    assign full     = (fill_reg == FW'(CAPACITY));
    assign issue    = scan_on_reg && (j_reg != fill_reg);
    assign cand     = rv_reg && cmd.emit_mode && (rcnt_reg == best_reg)
                      && (!have_prev_reg || (rdata_reg > prev_reg));
    assign best_ext = CMPW'(best_reg);
    assign occ_sat  = (best_ext > CMPW'(OCC_MAX)) ? OCC_W'(OCC_MAX) : OCC_W'(best_ext);
    assign best_next = (occ_reg > best_reg) ? occ_reg : best_reg;

    assign status.scan_done = !scan_on_reg && !rv_reg;
    assign status.i_last    = (FW'(i_reg) == (fill_reg - FW'(1)));
    assign status.emit_last = !have2_reg || (emitted_reg == OCC_W'(MAX_RESULTS - 1));
    assign status.out_free  = !out_valid_reg || !mode_stall;

    // storage
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            store_mem[fill_reg[IW-1:0]] <= value;
        end
        if (cmd.cnt_commit)
        begin
            cnt_mem[i_reg] <= occ_reg;
        end
        if (issue)
        begin
            rdata_reg <= store_mem[j_reg[IW-1:0]];
            rcnt_reg  <= cnt_mem[j_reg[IW-1:0]];
        end
        if (cmd.cnt_start)
        begin
            key_reg <= store_mem[i_reg];
        end
    end

    // fill level and search control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            scan_on_reg   <= 1'b0;
            rv_reg        <= 1'b0;
            occ_reg       <= '0;
            best_reg      <= '0;
            have_prev_reg <= 1'b0;
            have1_reg     <= 1'b0;
            have2_reg     <= 1'b0;
            emitted_reg   <= '0;
        end
        else
        begin
            rv_reg <= issue;
            if (issue)
            begin
                j_reg <= j_reg + FW'(1);
            end
            else if (scan_on_reg)
            begin
                scan_on_reg <= 1'b0;
            end

            if (cmd.load)
            begin
                if (!full)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                if (is_last)
                begin
                    i_reg         <= '0;
                    best_reg      <= '0;
                    have_prev_reg <= 1'b0;
                    emitted_reg   <= '0;
                end
            end

            if (cmd.cnt_start)
            begin
                j_reg       <= '0;
                scan_on_reg <= 1'b1;
                occ_reg     <= '0;
            end

            if (rv_reg && cmd.cnt_mode && (rdata_reg == key_reg))
            begin
                occ_reg <= occ_reg + FW'(1);
            end

            if (cmd.cnt_commit)
            begin
                best_reg <= best_next;
                i_reg    <= i_reg + IW'(1);
            end

            if (cmd.emit_start)
            begin
                j_reg       <= '0;
                scan_on_reg <= 1'b1;
                have1_reg   <= 1'b0;
                have2_reg   <= 1'b0;
            end

            // keep the two smallest distinct tied values above the last result
            if (cand)
            begin
                if (!have1_reg || (rdata_reg < min1_reg))
                begin
                    have2_reg <= have1_reg;
                    have1_reg <= 1'b1;
                end
                else if ((rdata_reg != min1_reg) && (!have2_reg || (rdata_reg < min2_reg)))
                begin
                    have2_reg <= 1'b1;
                end
            end

            if (cmd.emit_commit)
            begin
                have_prev_reg <= 1'b1;
                emitted_reg   <= emitted_reg + OCC_W'(1);
                if (status.emit_last)
                begin
                    fill_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand)
        begin
            if (!have1_reg || (rdata_reg < min1_reg))
            begin
                min2_reg <= min1_reg;
                min1_reg <= rdata_reg;
            end
            else if ((rdata_reg != min1_reg) && (!have2_reg || (rdata_reg < min2_reg)))
            begin
                min2_reg <= rdata_reg;
            end
        end
        if (cmd.emit_commit)
        begin
            prev_reg      <= min1_reg;
            out_value_reg <= min1_reg;
            out_occ_reg   <= occ_sat;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= status.emit_last;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!mode_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign mode_valid  = out_valid_reg;
    assign mode_value  = out_value_reg;
    assign occurrences = out_occ_reg;
    assign overflow    = out_ovf_reg;
    assign last_mode   = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(CAPACITY))
        else $error("fill level above capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> full)
        else $error("overflow flagged while store not full");

    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_commit |-> (have1_reg && (best_reg != '0)))
        else $error("result emitted without a tied value");

    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_commit && have_prev_reg) |-> (min1_reg > prev_reg))
        else $error("tied values not ascending");

endmodule

// ===== hw/rtl/multiset_mode_finder.sv =====
// Top level of the multiset mode finder: controller plus datapath.
`timescale 1ns / 1ps

// Members of a set are taken one request per cycle while the block is idle
// and stored, up to CAPACITY of them; further members are dropped and flag
// overflow. The request marked last starts the search: for each stored member
// i the store is scanned once, through the single scan port of the item
// store, to count its occurrences. Each tied result then takes one further
// scan, and its output waits while the previous result waits to be taken; it
// is produced in ascending order, with the final one marked last_mode. The
// next set may start while the final result still waits to be taken. No
// input is taken during the search.

module multiset_mode_finder
    import mmf_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [VALUE_W-1:0] value,
    input  logic               is_last,
    output logic               mode_valid,
    input  logic               mode_stall,
    output logic [VALUE_W-1:0] mode_value,
    output logic [OCC_W-1:0]   occurrences,
    output logic               overflow,
    output logic               last_mode
);

    cmd_t    cmd;
    status_t status;

    mmf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .is_last    (is_last),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    mmf_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value       (value),
        .is_last     (is_last),
        .mode_valid  (mode_valid),
        .mode_stall  (mode_stall),
        .mode_value  (mode_value),
        .occurrences (occurrences),
        .overflow    (overflow),
        .last_mode   (last_mode)
    );

endmodule

// ===== tb/sv/tb_multiset_mode_finder.sv =====
// Self-checking testbench for multiset_mode_finder: a tie-aware predictor checks every result.
`timescale 1ns / 1ps

module tb_multiset_mode_finder;
    import mmf_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TARGET_ITEMS   = 480;
    localparam int QUIET_CYCLES   = 300;
    localparam int MAX_PRINTED    = 40;

    typedef struct packed {
        logic [VALUE_W-1:0] mode_value;
        logic [OCC_W-1:0]   occurrences;
        logic               overflow;
        logic               last_mode;
    } mode_result_t;

    class mode_scoreboard;
        int unsigned        depth;
        logic [VALUE_W-1:0] members[$];
        bit                 dropped;
        mode_result_t       pending_modes[$];
        int unsigned        errors;
        int unsigned        requests_seen;
        int unsigned        sets_closed;
        int unsigned        overflow_sets;
        int unsigned        results_seen;
        int unsigned        widest_tie;

        function new(int unsigned store_depth);
            depth = store_depth;
        endfunction

        task report(string what);
            if (errors < MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        // stores the member; on the final one predicts the tied modes, ascending
        function void take_member(logic [VALUE_W-1:0] v, logic is_final);
            logic [VALUE_W-1:0] sorted[$];
            logic [VALUE_W-1:0] run_value[$];
            int unsigned        run_len[$];
            int unsigned        best;
            int unsigned        ties;
            int unsigned        emitted;
            int unsigned        i;
            int unsigned        j;
            mode_result_t       r;
            requests_seen++;
            if (members.size() < depth)
                members = {members, v};
            else
                dropped = 1'b1;
            if (!is_final)
                return;
            sorted = members;
            sorted.sort();
            best = 0;
            i = 0;
            while (i < sorted.size())
            begin
                j = i;
                while (j < sorted.size() && sorted[j] == sorted[i])
                    j++;
                run_value = {run_value, sorted[i]};
                run_len   = {run_len, j - i};
                if (j - i > best)
                    best = j - i;
                i = j;
            end
            ties = 0;
            for (i = 0; i < run_len.size(); i++)
                if (run_len[i] == best)
                    ties++;
            if (ties > MAX_RESULTS)
                ties = MAX_RESULTS;
            emitted = 0;
            for (i = 0; i < run_len.size() && emitted < ties; i++)
            begin
                if (run_len[i] == best)
                begin
                    r.mode_value  = run_value[i];
                    r.occurrences = (best > OCC_MAX) ? OCC_W'(OCC_MAX) : OCC_W'(best);
                    r.overflow    = dropped;
                    r.last_mode   = (emitted + 1 == ties);
                    pending_modes = {pending_modes, r};
                    emitted++;
                end
            end
            sets_closed++;
            if (dropped)
                overflow_sets++;
            if (ties > widest_tie)
                widest_tie = ties;
            members.delete();
            dropped = 1'b0;
        endfunction

        task check_result(mode_result_t got);
            mode_result_t want;
            results_seen++;
            if (pending_modes.size() == 0)
            begin
                report($sformatf("result %0d with none predicted: value %h occ %0d",
                                 results_seen, got.mode_value, got.occurrences));
                return;
            end
            want = pending_modes.pop_front();
            if (got.mode_value !== want.mode_value)
                report($sformatf("result %0d mode_value %h, predicted %h",
                                 results_seen, got.mode_value, want.mode_value));
            if (got.occurrences !== want.occurrences)
                report($sformatf("result %0d occurrences %0d, predicted %0d",
                                 results_seen, got.occurrences, want.occurrences));
            if (got.overflow !== want.overflow)
                report($sformatf("result %0d overflow %b, predicted %b",
                                 results_seen, got.overflow, want.overflow));
            if (got.last_mode !== want.last_mode)
                report($sformatf("result %0d last_mode %b, predicted %b",
                                 results_seen, got.last_mode, want.last_mode));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [VALUE_W-1:0] value;
    logic               is_last;
    logic               mode_valid;
    logic               mode_stall;
    logic [VALUE_W-1:0] mode_value;
    logic [OCC_W-1:0]   occurrences;
    logic               overflow;
    logic               last_mode;

    mode_scoreboard sb = new(CAPACITY);
    int             items_sent = 0;
    bit             hold_req = 1'b0;
    bit             hold_active = 1'b0;

    always #2 clk = ~clk;

    multiset_mode_finder #(.CAPACITY(CAPACITY)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .value       (value),
        .is_last     (is_last),
        .mode_valid  (mode_valid),
        .mode_stall  (mode_stall),
        .mode_value  (mode_value),
        .occurrences (occurrences),
        .overflow    (overflow),
        .last_mode   (last_mode)
    );

    always @(posedge clk)
    begin : monitor
        mode_result_t got;
        if (rst_n === 1'b1)
        begin
            if (item_valid && !item_stall)
                sb.take_member(value, is_last);
            if (mode_valid && !mode_stall)
            begin
                got = {mode_value, occurrences, overflow, last_mode};
                sb.check_result(got);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value(int flavor, logic [VALUE_W-1:0] base);
        case (flavor)
            0: return $urandom;
            1: return base + VALUE_W'($urandom_range(0, 3));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return base ^ (32'h1 << $urandom_range(0, 31));
        endcase
    endfunction

    task automatic offer(input logic [VALUE_W-1:0] v, input logic is_final, input bit tight);
        int gap;
        gap = tight ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        is_last    <= is_final;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_set(input logic [VALUE_W-1:0] vals[$], input bit tight);
        foreach (vals[k])
            offer(vals[k], k == vals.size() - 1, tight);
    endtask

    task automatic random_set(input int size, input int flavor);
        logic [VALUE_W-1:0] vals[$];
        logic [VALUE_W-1:0] base;
        bit                 tight;
        base  = $urandom;
        tight = ($urandom_range(0, 4) == 0);
        repeat (size) vals = {vals, draw_value(flavor, base)};
        send_set(vals, tight);
    endtask

    // drop valid so the last request is not offered twice
    task automatic pause_sender();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_modes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : receiver
        int r;
        int span;
        mode_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                mode_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    mode_stall <= 1'b0;
                    span = $urandom_range(1, 24);
                end
                else if (r < 88)
                begin
                    mode_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end
                else if (r < 97)
                begin
                    mode_stall <= 1'b1;
                    span = $urandom_range(4, 12);
                end
                else
                begin
                    mode_stall <= 1'b1;
                    span = $urandom_range(30, 80);
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (mode_valid && !mode_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_multiset_mode_finder failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [VALUE_W-1:0] vals[$];
        int                 r;
        bit                 pressure_done;
        bit                 pause_done;
        pressure_done = 1'b0;
        pause_done    = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        value      <= '0;
        is_last    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-member sets at both ends of the range
        vals = '{32'h0000_0000};
        send_set(vals, 1'b0);
        vals = '{32'hFFFF_FFFF};
        send_set(vals, 1'b0);
        // two-way tie, one clear mode, all distinct, three-way tie
        vals = '{32'd5, 32'd3, 32'd5, 32'd3, 32'd9};
        send_set(vals, 1'b0);
        vals = '{32'd7, 32'd7, 32'd7, 32'd1, 32'd2};
        send_set(vals, 1'b1);
        vals = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h1};
        send_set(vals, 1'b0);
        vals = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h0};
        send_set(vals, 1'b0);
        pause_sender();
        wait_drained();

        // full store without drop, last dropped on a full store, heavy overflow
        random_set(CAPACITY, 0);
        random_set(CAPACITY + 1, 0);
        random_set(CAPACITY + 8, 1);

        while (items_sent < TARGET_ITEMS)
        begin
            if (!pressure_done && items_sent >= 220)
            begin
                pressure_done = 1'b1;
                pause_sender();
                hold_req = 1'b1;
                wait (hold_active);
                random_set(10, 1);
                random_set(8, 3);
                random_set(8, 1);
            end
            if (!pause_done && items_sent >= 360)
            begin
                pause_done = 1'b1;
                pause_sender();
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 82)
                random_set($urandom_range(1, 16), $urandom_range(0, 3));
            else if (r < 94)
                random_set($urandom_range(17, 40), $urandom_range(0, 3));
            else
                random_set($urandom_range(CAPACITY - 4, CAPACITY + 8), $urandom_range(0, 3));
        end

        pause_sender();
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge clk);

        $display("Run covered %0d requests in %0d sets, %0d of them past store capacity.",
                 sb.requests_seen, sb.sets_closed, sb.overflow_sets);
        $display("Checked %0d mode results, widest tie %0d values, %0d mismatches.",
                 sb.results_seen, sb.widest_tie, sb.errors);
        if (sb.errors == 0)
            $display("tb_multiset_mode_finder passed");
        else
            $display("tb_multiset_mode_finder failed");
        $finish;
    end

endmodule

// ===== multiset_mode_finder.f =====
hw/rtl/mmf_pkg.sv
hw/rtl/mmf_ctrl.sv
hw/rtl/mmf_datapath.sv
hw/rtl/multiset_mode_finder.sv
tb/sv/tb_multiset_mode_finder.sv
